[rtl/core/kdpc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kdpc_pkg
// Shared types and constants of the key debouncer with release counter.
// ----------------------------------------------------------------------------
package kdpc_pkg;

    localparam int unsigned CountW   = 8;
    localparam int unsigned TimerW   = 9;
    localparam int unsigned CfgW     = 8;
    localparam int unsigned ApbAddrW = 4;
    localparam int unsigned ApbDataW = 32;

    localparam logic [CountW-1:0] ReleaseCeiling = 8'd250;
    localparam logic [TimerW-1:0] TimerMax       = 9'd511;

    localparam logic [CfgW-1:0] DebounceReset = 8'd20;
    localparam logic [CfgW-1:0] PeriodReset   = 8'd10;
    localparam logic [CfgW-1:0] LimitReset    = 8'd250;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_PERIOD   = 2'd1;
    localparam logic [1:0] REG_LIMIT    = 2'd2;

    // item kinds carried on tuser
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_ACCESS = 1'b1;

    typedef enum logic [1:0] {
        PH_UP             = 2'd0,
        PH_PRESS_WOBBLE   = 2'd1,
        PH_DOWN           = 2'd2,
        PH_RELEASE_WOBBLE = 2'd3
    } t_phase;

    typedef struct packed {
        logic cmd;
        logic key_level;
        logic do_write;
        logic do_clear;
        logic do_decrement;
        logic do_increment;
    } t_item;

    typedef struct packed {
        logic [CfgW-1:0] debounce_ms;
        logic [CfgW-1:0] tick_period_ms;
        logic [CfgW-1:0] count_limit;
    } t_cfg;

    typedef struct packed {
        t_phase            key_phase;
        logic [CountW-1:0] press_count;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/kdpc_apb_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kdpc_apb_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module kdpc_apb_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [kdpc_pkg::ApbAddrW-1:0]      paddr,
    input  wire logic [kdpc_pkg::ApbDataW-1:0]      pwdata,
    output logic      [kdpc_pkg::ApbDataW-1:0]      prdata,
    output logic                                    pready,
    output kdpc_pkg::t_cfg                          o_cfg
);

    kdpc_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= kdpc_pkg::DebounceReset;
            r_cfg.tick_period_ms <= kdpc_pkg::PeriodReset;
            r_cfg.count_limit    <= kdpc_pkg::LimitReset;
        end else if (wr_en) begin
            case (reg_idx)
                kdpc_pkg::REG_DEBOUNCE: r_cfg.debounce_ms    <= pwdata[kdpc_pkg::CfgW-1:0];
                kdpc_pkg::REG_PERIOD:   r_cfg.tick_period_ms <= pwdata[kdpc_pkg::CfgW-1:0];
                kdpc_pkg::REG_LIMIT:    r_cfg.count_limit    <= pwdata[kdpc_pkg::CfgW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            kdpc_pkg::REG_DEBOUNCE: prdata[kdpc_pkg::CfgW-1:0] = r_cfg.debounce_ms;
            kdpc_pkg::REG_PERIOD:   prdata[kdpc_pkg::CfgW-1:0] = r_cfg.tick_period_ms;
            kdpc_pkg::REG_LIMIT:    prdata[kdpc_pkg::CfgW-1:0] = r_cfg.count_limit;
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[rtl/core/kdpc_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kdpc_engine
// Debounce phase machine, settle timer and release counter for one item.
// ----------------------------------------------------------------------------
module kdpc_engine (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire kdpc_pkg::t_item i_item,
    input  wire kdpc_pkg::t_cfg  i_cfg,
    output kdpc_pkg::t_result   o_result
);

    localparam logic [kdpc_pkg::CountW-1:0] CountOne = {{(kdpc_pkg::CountW-1){1'b0}}, 1'b1};

    kdpc_pkg::t_phase                  r_phase,  n_phase;
    logic [kdpc_pkg::TimerW-1:0]       r_timer,  n_timer;
    logic [kdpc_pkg::CountW-1:0]       r_count,  n_count;

    logic [kdpc_pkg::TimerW:0]         timer_sum;
    logic [kdpc_pkg::TimerW-1:0]       timer_adv;
    logic                              settled;
    logic [kdpc_pkg::CountW-1:0]       cnt_clr;
    logic [kdpc_pkg::CountW-1:0]       cnt_dec;

    // saturating timer advance and settle decision
    assign timer_sum = {1'b0, r_timer} + {2'b00, i_cfg.tick_period_ms};
    assign timer_adv = timer_sum[kdpc_pkg::TimerW] ? kdpc_pkg::TimerMax
                                                   : timer_sum[kdpc_pkg::TimerW-1:0];
    assign settled   = timer_adv >= {1'b0, i_cfg.debounce_ms};

    // access: clear, then decrement, then increment
    assign cnt_clr = i_item.do_clear ? '0 : r_count;
    assign cnt_dec = (i_item.do_decrement && cnt_clr != '0) ? cnt_clr - CountOne : cnt_clr;

    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_count = r_count;
        if (i_item.cmd == kdpc_pkg::CMD_TICK) begin
            case (r_phase)
                kdpc_pkg::PH_UP: begin
                    if (i_item.key_level) begin
                        n_timer = '0;
                        n_phase = kdpc_pkg::PH_PRESS_WOBBLE;
                    end
                end
                kdpc_pkg::PH_PRESS_WOBBLE: begin
                    n_timer = timer_adv;
                    if (settled) begin
                        n_phase = i_item.key_level ? kdpc_pkg::PH_DOWN : kdpc_pkg::PH_UP;
                    end
                end
                kdpc_pkg::PH_DOWN: begin
                    if (!i_item.key_level) begin
                        n_timer = '0;
                        n_phase = kdpc_pkg::PH_RELEASE_WOBBLE;
                    end
                end
                default: begin
                    n_timer = timer_adv;
                    if (settled) begin
                        if (!i_item.key_level) begin
                            n_phase = kdpc_pkg::PH_UP;
                            n_count = (r_count >= kdpc_pkg::ReleaseCeiling)
                                    ? kdpc_pkg::ReleaseCeiling : r_count + CountOne;
                        end else begin
                            n_phase = kdpc_pkg::PH_DOWN;
                        end
                    end
                end
            endcase
        end else if (i_item.do_write) begin
            n_count = (i_item.do_increment && cnt_dec != i_cfg.count_limit)
                    ? cnt_dec + CountOne : cnt_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= kdpc_pkg::PH_DOWN;
            r_timer <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_count <= n_count;
        end
    end

    assign o_result.press_count = n_count;
    assign o_result.key_phase   = n_phase;

endmodule
`default_nettype wire

[rtl/core/key_debounce_press_counter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// key_debounce_press_counter
// Four-phase key debouncer with a saturating release counter and count access.
// ----------------------------------------------------------------------------
// Stages: input register, then result register; the phase, timer and count update
//   as a request moves from the input register into the result register.
// Throughput: one request per cycle unless the result stalls; the state update is the loop.
// Reset (i_rst_n low, synchronous): empty both stages, phase down, timer and
//   count zero, registers back to 20 ms / 10 ms / limit 250.
// ----------------------------------------------------------------------------
module key_debounce_press_counter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [0] key_level, [1] do_write, [2] do_clear,
                                            // [3] do_decrement, [4] do_increment, [7:5] zero
    input  wire logic [0:0]  s_axis_tuser,  // [0] cmd: 0 tick, 1 count access
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [7:0] press_count, [9:8] key_phase, [15:10] zero
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    kdpc_pkg::t_cfg    cfg;
    kdpc_pkg::t_item   in_item;
    kdpc_pkg::t_result step_res;

    logic              r_in_valid;
    kdpc_pkg::t_item   r_in_item;
    logic              r_out_valid;
    kdpc_pkg::t_result r_out_res;

    logic              advance;
    logic              in_fire;

    // -- configuration registers --
    kdpc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // -- unpack the request --
    assign in_item.cmd          = s_axis_tuser[0];
    assign in_item.key_level    = s_axis_tdata[0];
    assign in_item.do_write     = s_axis_tdata[1];
    assign in_item.do_clear     = s_axis_tdata[2];
    assign in_item.do_decrement = s_axis_tdata[3];
    assign in_item.do_increment = s_axis_tdata[4];

    // Move the held request into the result register whenever that register
    // is empty or its contents leave this cycle; the input stage refills in
    // the same cycle, so a stalled result only holds the pipe, it does not
    // drain it.
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = r_in_valid && advance;

    // -- input register --
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= in_item;
        end
    end

    // -- phase machine, timer and counter; state commits on in_fire --
    kdpc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    // -- result register --
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_res <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_out_res.key_phase, r_out_res.press_count};

endmodule
`default_nettype wire

[rtl/core/kdpc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kdpc_checker
// Port-level checks of the key debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module kdpc_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata
);

    logic [1:0] r_last_phase;
    logic       out_fire;

    assign out_fire = m_axis_tvalid && m_axis_tready;

    // track the phase of the last delivered result; reset phase is down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= kdpc_pkg::PH_DOWN;
        end else if (out_fire) begin
            r_last_phase <= m_axis_tdata[9:8];
        end
    end

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // an empty result stage never blocks requests
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request blocked with empty result stage");

    // up never jumps straight to down, and down never jumps straight to up
    a_no_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |-> !((r_last_phase == kdpc_pkg::PH_UP
                        && m_axis_tdata[9:8] == kdpc_pkg::PH_DOWN)
                    || (r_last_phase == kdpc_pkg::PH_DOWN
                        && m_axis_tdata[9:8] == kdpc_pkg::PH_UP)))
        else $error("phase skipped a wobble phase");

    // padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:10] == 6'b000000)
        else $error("nonzero padding in result");

endmodule

bind key_debounce_press_counter kdpc_checker u_kdpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
